[hdl/six_register_instruction_executor_unit_assert.svh]
// Assertion macros used by the executor's top-level RTL file.
`ifndef SIX_REGISTER_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`define SIX_REGISTER_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRIE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("six_register_instruction_executor_unit: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("six_register_instruction_executor_unit: assertion failed");

`endif

[hdl/srie_pkg.sv]
// Package with the types and constants of the six register instruction executor.
package srie_pkg;

	localparam int NUM_REGS_DEF    = 6;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int DATA_W          = 32;
	localparam int IP_W            = 3;
	localparam int PLEN_W          = 16;
	localparam int DEST_W          = 3;
	localparam int OPCODE_W        = 4;
	localparam int CFG_INDEX_W     = 1;
	localparam int CFG_DATA_W      = 16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADDR, OP_ADDI, OP_MULR, OP_MULI,
		OP_BANR, OP_BANI, OP_BORR, OP_BORI,
		OP_SETR, OP_SETI, OP_GTIR, OP_GTRI,
		OP_GTRR, OP_EQIR, OP_EQRI, OP_EQRR
	} opcode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_IP_REGISTER    = 1'b0,
		CFG_PROGRAM_LENGTH = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ALU_ADD, ALU_MUL, ALU_AND, ALU_OR, ALU_SET, ALU_GT, ALU_EQ
	} alu_t;

	typedef struct packed {
		alu_t              alu;
		logic              a_reg;
		logic              b_reg;
		logic              a_bad;
		logic              b_bad;
		logic              dest_bad;
		logic [DEST_W-1:0] dest;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} entry_t;

	typedef struct packed {
		logic [IP_W-1:0]   ip_register;
		logic [PLEN_W-1:0] program_length;
	} cfg_t;

endpackage

[hdl/srie_front.sv]
// Front end: accepts instructions and classifies opcode and operand indexes.
module srie_front #(
	parameter int NUM_REGS = srie_pkg::NUM_REGS_DEF
) (
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [srie_pkg::OPCODE_W-1:0]       opcode,
	input  logic signed [srie_pkg::DATA_W-1:0]  operand_a,
	input  logic signed [srie_pkg::DATA_W-1:0]  operand_b,
	input  logic [srie_pkg::DEST_W-1:0]         dest_index,
	output logic                                push_valid,
	input  logic                                push_stall,
	output srie_pkg::entry_t                    push_data
);

	localparam logic [srie_pkg::DATA_W-1:0] NUM_REGS_U = srie_pkg::DATA_W'(NUM_REGS);

	srie_pkg::alu_t    alu;
	logic              a_reg;
	logic              b_reg;
	srie_pkg::opcode_t op;

	assign op         = srie_pkg::opcode_t'(opcode);
	assign push_valid = in_valid;
	assign in_stall   = push_stall;

	always_comb begin
		alu   = srie_pkg::ALU_ADD;
		a_reg = 1'b1;
		b_reg = 1'b0;
		unique case (op)
			srie_pkg::OP_ADDR: begin
				alu   = srie_pkg::ALU_ADD;
				b_reg = 1'b1;
			end
			srie_pkg::OP_ADDI: alu = srie_pkg::ALU_ADD;
			srie_pkg::OP_MULR: begin
				alu   = srie_pkg::ALU_MUL;
				b_reg = 1'b1;
			end
			srie_pkg::OP_MULI: alu = srie_pkg::ALU_MUL;
			srie_pkg::OP_BANR: begin
				alu   = srie_pkg::ALU_AND;
				b_reg = 1'b1;
			end
			srie_pkg::OP_BANI: alu = srie_pkg::ALU_AND;
			srie_pkg::OP_BORR: begin
				alu   = srie_pkg::ALU_OR;
				b_reg = 1'b1;
			end
			srie_pkg::OP_BORI: alu = srie_pkg::ALU_OR;
			srie_pkg::OP_SETR: alu = srie_pkg::ALU_SET;
			srie_pkg::OP_SETI: begin
				alu   = srie_pkg::ALU_SET;
				a_reg = 1'b0;
			end
			srie_pkg::OP_GTIR: begin
				alu   = srie_pkg::ALU_GT;
				a_reg = 1'b0;
				b_reg = 1'b1;
			end
			srie_pkg::OP_GTRI: alu = srie_pkg::ALU_GT;
			srie_pkg::OP_GTRR: begin
				alu   = srie_pkg::ALU_GT;
				b_reg = 1'b1;
			end
			srie_pkg::OP_EQIR: begin
				alu   = srie_pkg::ALU_EQ;
				a_reg = 1'b0;
				b_reg = 1'b1;
			end
			srie_pkg::OP_EQRI: alu = srie_pkg::ALU_EQ;
			srie_pkg::OP_EQRR: begin
				alu   = srie_pkg::ALU_EQ;
				b_reg = 1'b1;
			end
		endcase
	end

	always_comb begin
		push_data.alu      = alu;
		push_data.a_reg    = a_reg;
		push_data.b_reg    = b_reg;
		push_data.a_bad    = a_reg && ($unsigned(operand_a) >= NUM_REGS_U);
		push_data.b_bad    = b_reg && ($unsigned(operand_b) >= NUM_REGS_U);
		push_data.dest_bad = {{(srie_pkg::DATA_W - srie_pkg::DEST_W){1'b0}}, dest_index}
			>= NUM_REGS_U;
		push_data.dest     = dest_index;
		push_data.a        = operand_a;
		push_data.b        = operand_b;
	end

endmodule

[hdl/srie_queue.sv]
// Short queue of classified instructions between the front and back ends.
module srie_queue #(
	parameter int DEPTH = srie_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_stall,
	input  srie_pkg::entry_t push_data,
	output logic             pop_valid,
	input  logic             pop_stall,
	output srie_pkg::entry_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	srie_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_stall = (count_q == FULL);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[hdl/srie_back.sv]
// Back end: operand read stage, execute stage, register file and output register.
module srie_back #(
	parameter int NUM_REGS = srie_pkg::NUM_REGS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  srie_pkg::cfg_t                     cfg,
	input  logic                               pop_valid,
	output logic                               pop_stall,
	input  srie_pkg::entry_t                   pop_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [srie_pkg::DATA_W-1:0] next_pc,
	output logic signed [srie_pkg::DATA_W-1:0] reg_zero,
	output logic                               halted,
	output logic                               bad_index
);

	localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int DW    = srie_pkg::DATA_W;
	localparam logic [DW-1:0] NUM_REGS_U = DW'(NUM_REGS);

	logic [DW-1:0]    regs_q [NUM_REGS];
	logic [DW-1:0]    regs_nx [NUM_REGS];

	logic             valid_s1;
	srie_pkg::alu_t   alu_s1;
	logic [DW-1:0]    va_s1;
	logic [DW-1:0]    vb_s1;
	logic [IDX_W-1:0] dest_s1;
	logic             dest_ok_s1;
	logic             bad_s1;

	logic             out_valid_q;
	logic [DW-1:0]    pc_q;
	logic [DW-1:0]    reg0_q;
	logic             bad_q;
	logic             unbound_q;

	logic             out_ready;
	logic             x_fire;
	logic             s1_load;
	logic             ip_bound;
	logic [IDX_W-1:0] ip_idx;
	logic [IDX_W-1:0] a_idx;
	logic [IDX_W-1:0] b_idx;
	logic [DW-1:0]    va_rd;
	logic [DW-1:0]    vb_rd;
	logic [DW-1:0]    vip;
	logic [DW-1:0]    res;
	logic [DW-1:0]    pc_new;

	assign ip_bound  = {{(DW - srie_pkg::IP_W){1'b0}}, cfg.ip_register} < NUM_REGS_U;
	assign ip_idx    = IDX_W'(cfg.ip_register);
	assign out_ready = !out_valid_q || !out_stall;
	assign x_fire    = valid_s1 && out_ready;
	assign s1_load   = pop_valid && (!valid_s1 || x_fire);
	assign pop_stall = valid_s1 && !x_fire;

	// Execute stage.
	always_comb begin
		unique case (alu_s1)
			srie_pkg::ALU_ADD: res = va_s1 + vb_s1;
			srie_pkg::ALU_MUL: res = va_s1 * vb_s1;
			srie_pkg::ALU_AND: res = va_s1 & vb_s1;
			srie_pkg::ALU_OR:  res = va_s1 | vb_s1;
			srie_pkg::ALU_SET: res = va_s1;
			srie_pkg::ALU_GT:  res = DW'($signed(va_s1) > $signed(vb_s1));
			srie_pkg::ALU_EQ:  res = DW'(va_s1 == vb_s1);
			default:           res = '0;
		endcase
	end

	assign vip    = ip_bound ? regs_q[ip_idx] : '0;
	assign pc_new = ((dest_ok_s1 && (dest_s1 == ip_idx)) ? res : vip) + DW'(1);

	// Register file contents after the instruction in the execute stage retires.
	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			regs_nx[i] = regs_q[i];
			if (x_fire) begin
				if (ip_bound && (ip_idx == IDX_W'(i))) begin
					regs_nx[i] = pc_new;
				end else if (dest_ok_s1 && (dest_s1 == IDX_W'(i))) begin
					regs_nx[i] = res;
				end
			end
		end
	end

	// Operand read, forwarded from the retiring instruction.
	assign a_idx = pop_data.a[IDX_W-1:0];
	assign b_idx = pop_data.b[IDX_W-1:0];
	assign va_rd = !pop_data.a_reg ? pop_data.a : (pop_data.a_bad ? '0 : regs_nx[a_idx]);
	assign vb_rd = !pop_data.b_reg ? pop_data.b : (pop_data.b_bad ? '0 : regs_nx[b_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= regs_nx[i];
			end
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (x_fire) begin
				valid_s1 <= 1'b0;
			end
			out_valid_q <= x_fire || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			alu_s1     <= pop_data.alu;
			va_s1      <= va_rd;
			vb_s1      <= vb_rd;
			dest_s1    <= IDX_W'(pop_data.dest);
			dest_ok_s1 <= !pop_data.dest_bad;
			bad_s1     <= pop_data.a_bad || pop_data.b_bad || pop_data.dest_bad;
		end
		if (x_fire) begin
			pc_q      <= ip_bound ? pc_new : '0;
			reg0_q    <= regs_nx[0];
			bad_q     <= bad_s1;
			unbound_q <= !ip_bound;
		end
	end

	assign out_valid = out_valid_q;
	assign next_pc   = pc_q;
	assign reg_zero  = reg0_q;
	assign bad_index = bad_q;
	assign halted    = unbound_q || pc_q[DW-1]
		|| (pc_q >= {{(DW - srie_pkg::PLEN_W){1'b0}}, cfg.program_length});

endmodule

[hdl/six_register_instruction_executor_unit.sv]
// Top level of the six register instruction executor.
//
// Instructions enter on the input channel (opcode, operand_a, operand_b,
// dest_index) and each one produces exactly one result on the output channel
// (next_pc, reg_zero, halted, bad_index), in order. Both channels transfer on
// a clock edge with valid high and stall low.
// Each instruction is registered in the queue and then the read stage, and its
// result in the output register; one executes per cycle while out_stall is low.
// The rate is set by the execute stage, which reads and writes the register
// file in the same cycle; operands are forwarded from it to the read stage.
// When the output is stalled, up to four instructions are held inside (two in
// the queue, one in the read stage, one in the output register) before the
// input stalls. The halted flag reports only; execution continues regardless.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user
// must do so only while no instruction is in flight, as the block does not
// enforce it. Reset clears the register file, binds register 1 to the program
// counter, sets the program length to zero and empties the pipeline.
`include "six_register_instruction_executor_unit_assert.svh"

module six_register_instruction_executor_unit #(
	parameter int NUM_REGS    = srie_pkg::NUM_REGS_DEF,
	parameter int QUEUE_DEPTH = srie_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [srie_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [srie_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [srie_pkg::OPCODE_W-1:0]        opcode,
	input  logic signed [srie_pkg::DATA_W-1:0]   operand_a,
	input  logic signed [srie_pkg::DATA_W-1:0]   operand_b,
	input  logic [srie_pkg::DEST_W-1:0]          dest_index,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [srie_pkg::DATA_W-1:0]   next_pc,
	output logic signed [srie_pkg::DATA_W-1:0]   reg_zero,
	output logic                                 halted,
	output logic                                 bad_index
);

	localparam logic [srie_pkg::DATA_W-1:0] NUM_REGS_U = srie_pkg::DATA_W'(NUM_REGS);

	logic [srie_pkg::IP_W-1:0]   ip_register_q;
	logic [srie_pkg::PLEN_W-1:0] program_length_q;
	srie_pkg::cfg_t              cfg;
	logic                        ip_bound;

	logic                        q_push_valid;
	logic                        q_push_stall;
	srie_pkg::entry_t            q_push_data;
	logic                        q_pop_valid;
	logic                        q_pop_stall;
	srie_pkg::entry_t            q_pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_register_q    <= srie_pkg::IP_W'(1);
			program_length_q <= '0;
		end else if (cfg_write) begin
			case (srie_pkg::cfg_index_t'(cfg_index))
				srie_pkg::CFG_IP_REGISTER:    ip_register_q    <= cfg_data[srie_pkg::IP_W-1:0];
				srie_pkg::CFG_PROGRAM_LENGTH: program_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.ip_register    = ip_register_q;
	assign cfg.program_length = program_length_q;
	assign ip_bound = {{(srie_pkg::DATA_W - srie_pkg::IP_W){1'b0}}, ip_register_q} < NUM_REGS_U;

	srie_front #(
		.NUM_REGS(NUM_REGS)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.dest_index (dest_index),
		.push_valid (q_push_valid),
		.push_stall (q_push_stall),
		.push_data  (q_push_data)
	);

	srie_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_stall (q_push_stall),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_stall  (q_pop_stall),
		.pop_data   (q_pop_data)
	);

	srie_back #(
		.NUM_REGS(NUM_REGS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (q_pop_valid),
		.pop_stall (q_pop_stall),
		.pop_data  (q_pop_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.next_pc   (next_pc),
		.reg_zero  (reg_zero),
		.halted    (halted),
		.bad_index (bad_index)
	);

	`SRIE_ASSERT_IMPL(a_full_not_empty, clk, arst_n, in_stall, q_pop_valid)
	`SRIE_ASSERT_NEXT(a_push_lands, clk, arst_n, in_valid && !in_stall && !q_pop_valid, q_pop_valid)
	`SRIE_ASSERT_IMPL(a_unbound_halts, clk, arst_n, out_valid && !ip_bound, halted && (next_pc == '0))

endmodule
